FILE: sv/hdbt_pkg.sv
// Shared types and constants for the half-duplex bus transaction controller.
`timescale 1ns / 1ps

package hdbt_pkg;

	localparam int unsigned LEN_W     = 16;
	localparam int unsigned GAP_W     = 8;
	localparam int unsigned RETRY_W   = 4;
	localparam int unsigned ELAPSED_W = LEN_W + 1;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = GAP_W;

	localparam logic [GAP_W-1:0]     GAP_RESET   = 8'd5;
	localparam logic [RETRY_W-1:0]   LIMIT_RESET = 4'd3;
	localparam logic [GAP_W-1:0]     GAP_MAX     = '1;
	localparam logic [RETRY_W-1:0]   RETRY_MAX   = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 1'd1;

	typedef enum logic [2:0] {
		KIND_TICK     = 3'd0,
		KIND_START    = 3'd1,
		KIND_TX_DONE  = 3'd2,
		KIND_RX_IDLE  = 3'd3,
		KIND_LINE_ERR = 3'd4,
		KIND_ACK      = 3'd5,
		KIND_CANCEL   = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_TX      = 3'd1,
		MODE_WAIT    = 3'd2,
		MODE_DONE    = 3'd3,
		MODE_TIMEOUT = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		START_NONE      = 2'd0,
		START_ACCEPTED  = 2'd1,
		START_PARAM_ERR = 2'd2,
		START_BUSY      = 2'd3
	} start_status_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [LEN_W-1:0] frame_length;
		logic [LEN_W-1:0] reply_capacity;
		logic [LEN_W-1:0] timeout_limit_ms;
		logic [LEN_W-1:0] received_count;
	} item_t;

	typedef struct packed {
		start_status_t      start_status;
		mode_t              bus_mode;
		logic               send_frame;
		logic               arm_receiver;
		logic               abort_transfer;
		logic [LEN_W-1:0]   reply_length;
		logic               line_error;
		logic               sequence_error;
		logic [RETRY_W-1:0] attempts_retried;
	} result_t;

	typedef struct packed {
		logic [GAP_W-1:0]   interframe_gap_ms;
		logic [RETRY_W-1:0] retry_limit;
	} cfg_t;

endpackage

FILE: sv/half_duplex_bus_transaction_ctrl.sv
// Top level of the half-duplex bus transaction controller.
`timescale 1ns / 1ps

// Master-side controller for one request/response transaction on a half-duplex bus.
// Each input transfer carries one event (ms tick, start, tx complete, rx idle, line
// error, acknowledge, cancel) and yields exactly one result transfer. One event is
// accepted per clock; the event is captured in the input register, its result is then
// loaded into the result register and is held there until taken. The only thing that
// slows acceptance is back-pressure on the result channel holding the result register.

module half_duplex_bus_transaction_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hdbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdbt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      kind,
	input  logic [hdbt_pkg::LEN_W-1:0]      frame_length,
	input  logic [hdbt_pkg::LEN_W-1:0]      reply_capacity,
	input  logic [hdbt_pkg::LEN_W-1:0]      timeout_limit_ms,
	input  logic [hdbt_pkg::LEN_W-1:0]      received_count,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      start_status,
	output logic [2:0]                      bus_mode,
	output logic                            send_frame,
	output logic                            arm_receiver,
	output logic                            abort_transfer,
	output logic [hdbt_pkg::LEN_W-1:0]      reply_length,
	output logic                            line_error,
	output logic                            sequence_error,
	output logic [hdbt_pkg::RETRY_W-1:0]    attempts_retried
);

	hdbt_pkg::cfg_t    cfg;
	hdbt_pkg::item_t   item_s1;
	hdbt_pkg::result_t result;
	hdbt_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	logic              fire;

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	hdbt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind             <= kind;
			item_s1.frame_length     <= frame_length;
			item_s1.reply_capacity   <= reply_capacity;
			item_s1.timeout_limit_ms <= timeout_limit_ms;
			item_s1.received_count   <= received_count;
		end
	end

	hdbt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	assign out_valid        = valid_s2;
	assign start_status     = res_s2.start_status;
	assign bus_mode         = res_s2.bus_mode;
	assign send_frame       = res_s2.send_frame;
	assign arm_receiver     = res_s2.arm_receiver;
	assign abort_transfer   = res_s2.abort_transfer;
	assign reply_length     = res_s2.reply_length;
	assign line_error       = res_s2.line_error;
	assign sequence_error   = res_s2.sequence_error;
	assign attempts_retried = res_s2.attempts_retried;

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |=> valid_s2 && $stable(res_s2))
		else $error("result dropped while stalled");

	a_no_fire_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ready |-> !fire)
		else $error("state advanced while result register full");

	a_input_held_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(item_s1))
		else $error("input register overwritten before use");

endmodule

FILE: sv/hdbt_cfg.sv
// Configuration register file for the bus transaction controller.
`timescale 1ns / 1ps

module hdbt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hdbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hdbt_pkg::CFG_DATA_W-1:0] cfg_data,
	output hdbt_pkg::cfg_t                 cfg
);

	logic [hdbt_pkg::GAP_W-1:0]   gap_q;
	logic [hdbt_pkg::RETRY_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q   <= hdbt_pkg::GAP_RESET;
			limit_q <= hdbt_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hdbt_pkg::CFG_IDX_GAP:   gap_q   <= cfg_data[hdbt_pkg::GAP_W-1:0];
				hdbt_pkg::CFG_IDX_LIMIT: limit_q <= cfg_data[hdbt_pkg::RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.interframe_gap_ms = gap_q;
	assign cfg.retry_limit       = limit_q;

endmodule

FILE: sv/hdbt_core.sv
// Transaction state registers and the single-pass event update.
`timescale 1ns / 1ps

module hdbt_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  hdbt_pkg::item_t   item,
	input  hdbt_pkg::cfg_t    cfg,
	output hdbt_pkg::result_t result
);

	hdbt_pkg::mode_t                  mode_q, mode_d;
	logic [hdbt_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d, elapsed_inc;
	logic [hdbt_pkg::GAP_W-1:0]       since_q, since_d;
	logic [hdbt_pkg::RETRY_W-1:0]     retry_q, retry_d, retry_inc;
	logic [hdbt_pkg::LEN_W-1:0]       timeout_q, timeout_d;
	logic [hdbt_pkg::LEN_W-1:0]       cap_q, cap_d;
	logic [hdbt_pkg::LEN_W-1:0]       reply_q, reply_d;
	logic                             line_err_q, line_err_d;
	logic                             seq_err_q, seq_err_d;
	logic                             active;
	hdbt_pkg::start_status_t          status;
	logic                             send, arm, abort_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= hdbt_pkg::MODE_IDLE;
			elapsed_q  <= '0;
			since_q    <= '0;
			retry_q    <= '0;
			timeout_q  <= '0;
			cap_q      <= '0;
			reply_q    <= '0;
			line_err_q <= 1'b0;
			seq_err_q  <= 1'b0;
		end else if (en) begin
			mode_q     <= mode_d;
			elapsed_q  <= elapsed_d;
			since_q    <= since_d;
			retry_q    <= retry_d;
			timeout_q  <= timeout_d;
			cap_q      <= cap_d;
			reply_q    <= reply_d;
			line_err_q <= line_err_d;
			seq_err_q  <= seq_err_d;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		elapsed_d  = elapsed_q;
		since_d    = since_q;
		retry_d    = retry_q;
		timeout_d  = timeout_q;
		cap_d      = cap_q;
		reply_d    = reply_q;
		line_err_d = line_err_q;
		seq_err_d  = seq_err_q;
		status     = hdbt_pkg::START_NONE;
		send       = 1'b0;
		arm        = 1'b0;
		abort_p    = 1'b0;
		active     = (mode_q == hdbt_pkg::MODE_TX) || (mode_q == hdbt_pkg::MODE_WAIT);
		elapsed_inc = (elapsed_q == hdbt_pkg::ELAPSED_MAX) ? elapsed_q
			: elapsed_q + 1'b1;
		retry_inc   = (retry_q == hdbt_pkg::RETRY_MAX) ? retry_q : retry_q + 1'b1;

		unique case (hdbt_pkg::kind_t'(item.kind))
			hdbt_pkg::KIND_TICK: begin
				if (since_q != hdbt_pkg::GAP_MAX)
					since_d = since_q + 1'b1;
				if (active) begin
					elapsed_d = elapsed_inc;
					if (elapsed_inc > {1'b0, timeout_q}) begin
						abort_p = 1'b1;
						retry_d = retry_inc;
						if (retry_inc >= cfg.retry_limit) begin
							mode_d = hdbt_pkg::MODE_TIMEOUT;
						end else begin
							reply_d   = '0;
							elapsed_d = '0;
							mode_d    = hdbt_pkg::MODE_TX;
							send      = 1'b1;
						end
					end
				end
			end
			hdbt_pkg::KIND_START: begin
				if (item.frame_length == '0 || item.reply_capacity == '0) begin
					status = hdbt_pkg::START_PARAM_ERR;
				end else if (mode_q != hdbt_pkg::MODE_IDLE
						|| since_q < cfg.interframe_gap_ms) begin
					status = hdbt_pkg::START_BUSY;
				end else begin
					status     = hdbt_pkg::START_ACCEPTED;
					cap_d      = item.reply_capacity;
					timeout_d  = item.timeout_limit_ms;
					elapsed_d  = '0;
					retry_d    = '0;
					reply_d    = '0;
					line_err_d = 1'b0;
					seq_err_d  = 1'b0;
					mode_d     = hdbt_pkg::MODE_TX;
					send       = 1'b1;
				end
			end
			hdbt_pkg::KIND_TX_DONE: begin
				if (mode_q != hdbt_pkg::MODE_TX) begin
					seq_err_d = 1'b1;
				end else begin
					arm    = 1'b1;
					mode_d = hdbt_pkg::MODE_WAIT;
				end
			end
			hdbt_pkg::KIND_RX_IDLE: begin
				if (mode_q != hdbt_pkg::MODE_WAIT) begin
					seq_err_d = 1'b1;
				end else begin
					reply_d = (item.received_count < cap_q) ? item.received_count : cap_q;
					mode_d  = hdbt_pkg::MODE_DONE;
					since_d = '0;
				end
			end
			hdbt_pkg::KIND_LINE_ERR: begin
				if (!active) begin
					seq_err_d = 1'b1;
				end else begin
					line_err_d = 1'b1;
					mode_d     = hdbt_pkg::MODE_TIMEOUT;
				end
			end
			hdbt_pkg::KIND_ACK, hdbt_pkg::KIND_CANCEL: begin
				abort_p    = (item.kind == hdbt_pkg::KIND_CANCEL) && active;
				reply_d    = '0;
				mode_d     = hdbt_pkg::MODE_IDLE;
				line_err_d = 1'b0;
				seq_err_d  = 1'b0;
				since_d    = '0;
			end
			default: ;
		endcase

		result.start_status     = status;
		result.bus_mode         = mode_d;
		result.send_frame       = send;
		result.arm_receiver     = arm;
		result.abort_transfer   = abort_p;
		result.reply_length     = reply_d;
		result.line_error       = line_err_d;
		result.sequence_error   = seq_err_d;
		result.attempts_retried = retry_d;
	end

	a_send_enters_tx: assert property (@(posedge clk) disable iff (!arst_n)
		en && result.send_frame |=> mode_q == hdbt_pkg::MODE_TX)
		else $error("send_frame without entering transmit");

	a_reply_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		reply_q != '0 |-> mode_q == hdbt_pkg::MODE_DONE)
		else $error("reply length held outside done");

	a_pulses_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> $countones({result.send_frame, result.arm_receiver}) <= 1)
		else $error("send and arm in one result");

	a_elapsed_cleared_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		en && result.send_frame |=> elapsed_q == '0)
		else $error("attempt time not restarted on send");

endmodule
